### rtl/length_prefixed_frame_deframer_defines.svh
// Assertion macros for the length-prefixed frame deframer.
// Used by the RTL files that carry concurrent checks; no other dependencies.
`ifndef LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH
`define LENGTH_PREFIXED_FRAME_DEFRAMER_DEFINES_SVH

// Same-cycle implication, disabled while in reset
`define LPFD_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, disabled while in reset
`define LPFD_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) \
    (ante) |=> (cons)) else $error(msg);

`endif

### rtl/lpfd_pkg.sv
// Shared types and constants for the length-prefixed frame deframer.
// No dependencies; imported by lpfd_decode and the top level.
package lpfd_pkg;

  // Bytes in each big-endian length field, and header geometry
  localparam int unsigned LenBytes = 8;
  localparam int unsigned HdrBytes = 2 * LenBytes;
  localparam int unsigned HdrLast  = HdrBytes - 1;

  typedef enum logic [1:0] {
    KindHeader  = 2'd0,
    KindName    = 2'd1,
    KindPayload = 2'd2
  } kind_e;

  // One decoded result word
  typedef struct packed {
    logic [63:0] payload_length;
    logic [63:0] name_length;
    logic        frame_done;
    logic        name_done;
    logic        header_done;
    kind_e       byte_kind;
    logic [7:0]  byte_value;
  } res_t;

endpackage

### rtl/length_prefixed_frame_deframer.sv
// Length-prefixed frame deframer: one byte word per cycle sustained while the receiver does not stall.
// Each result word passes the input register, then the result register, before it leaves.
// Throughput: one word per cycle unless the receiver stalls, limited by the single decode pass per byte.
// Reset (rst_ni low, asynchronous): both stages empty, position and lengths zero.
`include "length_prefixed_frame_deframer_defines.svh"

module length_prefixed_frame_deframer (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          s_axis_tvalid,
  output logic          s_axis_tready,
  input  logic [7:0]    s_axis_tdata,   // [7:0] stream_byte
  output logic          m_axis_tvalid,
  input  logic          m_axis_tready,
  // [7:0] byte_value, [8] header_done, [9] name_done,
  // [73:10] name_length, [137:74] payload_length, [143:138] zero
  output logic [143:0]  m_axis_tdata,
  output logic          m_axis_tlast,   // frame_done
  output logic [1:0]    m_axis_tuser    // [1:0] byte_kind
);
  import lpfd_pkg::*;

  logic       in_valid_q, in_valid_d;
  logic [7:0] in_byte_q;
  logic       out_valid_q, out_valid_d;
  res_t       out_res_q;
  res_t       dec_res;
  logic       s_fire, advance;

  // Handshake: a word moves on whenever the result register frees up
  assign advance       = in_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || !out_valid_q || m_axis_tready;
  assign s_fire        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    in_valid_d = in_valid_q;
    if (s_fire) begin
      in_valid_d = 1'b1;
    end else if (advance) begin
      in_valid_d = 1'b0;
    end
    out_valid_d = out_valid_q;
    if (advance) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      in_valid_q  <= in_valid_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Capture the incoming byte and the decoded result
  always_ff @(posedge clk_i) begin
    if (s_fire) begin
      in_byte_q <= s_axis_tdata;
    end
    if (advance) begin
      out_res_q <= dec_res;
    end
  end

  lpfd_decode u_decode (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .fire_i (advance),
    .byte_i (in_byte_q),
    .res_o  (dec_res)
  );

  // Drive the output word
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {6'd0, out_res_q.payload_length, out_res_q.name_length,
                          out_res_q.name_done, out_res_q.header_done,
                          out_res_q.byte_value};
  assign m_axis_tlast  = out_res_q.frame_done;
  assign m_axis_tuser  = out_res_q.byte_kind;

  // A header-completing byte is always classed as header
  `LPFD_ASSERT_NOW(a_hdr_kind, m_axis_tvalid && m_axis_tdata[8], m_axis_tuser == KindHeader, "header_done on non-header byte")
  // A frame end outside the header byte falls on a name or payload byte
  `LPFD_ASSERT_NOW(a_end_kind, m_axis_tvalid && m_axis_tlast && !m_axis_tdata[8], m_axis_tuser == KindName || m_axis_tuser == KindPayload, "frame end on header byte")
  // Name end on a header byte only happens with the header completing
  `LPFD_ASSERT_NOW(a_name_hdr, m_axis_tvalid && m_axis_tdata[9] && m_axis_tuser == KindHeader, m_axis_tdata[8], "name_done inside header")
  // A held input word stays put until it moves on
  `LPFD_ASSERT_NEXT(a_in_hold, in_valid_q && !advance, in_valid_q && $stable(in_byte_q), "input stage lost its word")

endmodule

### rtl/lpfd_decode.sv
// Frame position tracking and per-byte classification for the deframer.
// Depends on lpfd_pkg for the header geometry, kind codes and result struct.
module lpfd_decode (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          fire_i,
  input  logic [7:0]    byte_i,
  output lpfd_pkg::res_t res_o
);
  import lpfd_pkg::*;

  logic [63:0] pos_q, pos_d;
  logic [63:0] nl_q, nl_d;
  logic [63:0] pl_q, pl_d;
  logic [63:0] name_end_q, name_end_d;
  logic [63:0] frame_end_q, frame_end_d;
  logic        known_q, known_d;

  logic [63:0] nl_new, pl_new, len_sum;
  logic        hdr_done, name_hit, frame_hit, known_new;
  kind_e       kind;

  // Shift header bytes in, classify the byte and work out the next state
  always_comb begin
    nl_new = nl_q;
    pl_new = pl_q;
    if (!known_q) begin
      if (pos_q < 64'(LenBytes)) begin
        nl_new = {nl_q[55:0], byte_i};
      end else begin
        pl_new = {pl_q[55:0], byte_i};
      end
    end
    hdr_done  = !known_q && (pos_q >= 64'(HdrLast));
    known_new = known_q || hdr_done;
    len_sum   = nl_new + pl_new;

    // On the header-completing byte the position is the last header offset,
    // so the end tests reduce to zero tests on the fresh lengths
    name_hit  = 1'b0;
    frame_hit = 1'b0;
    kind      = KindHeader;
    if (hdr_done) begin
      name_hit  = (nl_new == 64'd0);
      frame_hit = (len_sum == 64'd0);
    end else if (known_q) begin
      name_hit  = (pos_q == name_end_q);
      frame_hit = (pos_q == frame_end_q);
      kind      = (pos_q <= name_end_q) ? KindName : KindPayload;
    end

    res_o.byte_value     = byte_i;
    res_o.byte_kind      = kind;
    res_o.header_done    = hdr_done;
    res_o.name_done      = name_hit;
    res_o.frame_done     = frame_hit;
    res_o.name_length    = known_new ? nl_new : 64'd0;
    res_o.payload_length = known_new ? pl_new : 64'd0;

    // Restart at the header after the last frame byte, else advance
    if (frame_hit) begin
      pos_d       = 64'd0;
      nl_d        = 64'd0;
      pl_d        = 64'd0;
      known_d     = 1'b0;
      name_end_d  = name_end_q;
      frame_end_d = frame_end_q;
    end else begin
      pos_d       = pos_q + 64'd1;
      nl_d        = nl_new;
      pl_d        = pl_new;
      known_d     = known_new;
      name_end_d  = hdr_done ? (nl_new + 64'(HdrLast)) : name_end_q;
      frame_end_d = hdr_done ? (len_sum + 64'(HdrLast)) : frame_end_q;
    end
  end

  // Update frame state once per byte handed to the output stage
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q       <= 64'd0;
      nl_q        <= 64'd0;
      pl_q        <= 64'd0;
      known_q     <= 1'b0;
      name_end_q  <= 64'd0;
      frame_end_q <= 64'd0;
    end else if (fire_i) begin
      pos_q       <= pos_d;
      nl_q        <= nl_d;
      pl_q        <= pl_d;
      known_q     <= known_d;
      name_end_q  <= name_end_d;
      frame_end_q <= frame_end_d;
    end
  end

endmodule

### sim/length_prefixed_frame_deframer_checker.sv
// Scoreboard for the length-prefixed frame deframer: watches both stream
// channels, predicts each output word from the accepted input bytes and compares.
// Depends on lpfd_pkg for the header geometry, the kind codes and the word layout.
module length_prefixed_frame_deframer_checker
  import lpfd_pkg::*;
(
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  input  logic         s_axis_tready,
  input  logic [7:0]   s_axis_tdata,
  input  logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  input  logic [143:0] m_axis_tdata,
  input  logic         m_axis_tlast,
  input  logic [1:0]   m_axis_tuser,
  output int           fail_count_o,
  output int           pending_count_o,
  output int           words_checked_o,
  output int           frames_checked_o
);

  localparam int MaxPrinted = 100;

  // Frame tracking state of the predictor
  logic [63:0] frame_pos;
  logic [63:0] name_len_q;
  logic [63:0] payload_len_q;
  logic        lens_valid;

  res_t expected_words[$];

  initial begin
    frame_pos        = '0;
    name_len_q       = '0;
    payload_len_q    = '0;
    lens_valid       = 1'b0;
    fail_count_o     = 0;
    pending_count_o  = 0;
    words_checked_o  = 0;
    frames_checked_o = 0;
  end

  // Print one mismatch line and count it
  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    if (fail_count_o < MaxPrinted) begin
      $display("mismatch at word %0d: %s got %0h, want %0h",
               words_checked_o, what, got, want);
    end
    fail_count_o++;
  endtask

  // Advance the frame tracker by one byte and return the word it should produce
  function automatic res_t decode_byte(input logic [7:0] b);
    res_t        w;
    logic        test_ends;
    logic [63:0] name_end;
    logic [63:0] frame_end;
    w              = '0;
    w.byte_value   = b;
    w.byte_kind    = KindHeader;
    test_ends      = 1'b0;
    // Shift header bytes into the length fields, big-endian
    if (!lens_valid) begin
      if (frame_pos < 64'(LenBytes)) begin
        name_len_q = {name_len_q[55:0], b};
      end else begin
        payload_len_q = {payload_len_q[55:0], b};
      end
      if (frame_pos >= 64'(HdrLast)) begin
        w.header_done = 1'b1;
        lens_valid    = 1'b1;
        test_ends     = 1'b1;
      end
    end else begin
      test_ends = 1'b1;
    end
    // End offsets wrap modulo 2^64
    if (test_ends) begin
      name_end  = name_len_q + 64'(HdrLast);
      frame_end = name_len_q + payload_len_q + 64'(HdrLast);
      if (!w.header_done) begin
        w.byte_kind = (frame_pos <= name_end) ? KindName : KindPayload;
      end
      w.name_done  = (frame_pos == name_end);
      w.frame_done = (frame_pos == frame_end);
    end
    w.name_length    = lens_valid ? name_len_q : '0;
    w.payload_length = lens_valid ? payload_len_q : '0;
    // Restart at the header after the last frame byte
    if (w.frame_done) begin
      frame_pos     = '0;
      name_len_q    = '0;
      payload_len_q = '0;
      lens_valid    = 1'b0;
    end else begin
      frame_pos = frame_pos + 64'd1;
    end
    return w;
  endfunction

  always @(posedge clk_i) begin
    res_t want;
    if (rst_ni) begin
      // Predict on every accepted input byte
      if (s_axis_tvalid && s_axis_tready) begin
        expected_words.push_back(decode_byte(s_axis_tdata));
      end
      // Compare every accepted output word with the oldest prediction
      if (m_axis_tvalid && m_axis_tready) begin
        if (expected_words.size() == 0) begin
          report_mismatch("unexpected word, data", m_axis_tdata[63:0], '0);
        end else begin
          want = expected_words.pop_front();
          if (m_axis_tdata[7:0] != want.byte_value)
            report_mismatch("byte_value", m_axis_tdata[7:0], want.byte_value);
          if (m_axis_tuser != want.byte_kind)
            report_mismatch("byte_kind", m_axis_tuser, want.byte_kind);
          if (m_axis_tdata[8] != want.header_done)
            report_mismatch("header_done", m_axis_tdata[8], want.header_done);
          if (m_axis_tdata[9] != want.name_done)
            report_mismatch("name_done", m_axis_tdata[9], want.name_done);
          if (m_axis_tlast != want.frame_done)
            report_mismatch("frame_done", m_axis_tlast, want.frame_done);
          if (m_axis_tdata[73:10] != want.name_length)
            report_mismatch("name_length", m_axis_tdata[73:10], want.name_length);
          if (m_axis_tdata[137:74] != want.payload_length)
            report_mismatch("payload_length", m_axis_tdata[137:74],
                            want.payload_length);
          if (m_axis_tdata[143:138] != '0)
            report_mismatch("padding", m_axis_tdata[143:138], '0);
          if (want.frame_done) frames_checked_o++;
        end
        words_checked_o++;
      end
      pending_count_o = expected_words.size();
    end
  end

endmodule

### sim/length_prefixed_frame_deframer_test.sv
// Testbench top for the length-prefixed frame deframer: drives framed byte
// streams with random idling on both sides and gives the verdict.
// Depends on the deframer RTL, lpfd_pkg and length_prefixed_frame_deframer_checker.
module length_prefixed_frame_deframer_test;

  localparam int RandomBytes = 1800;
  localparam int QuietTail   = 300;
  localparam int CycleLimit  = 400000;

  logic         clk_i;
  logic         rst_ni;
  logic         s_axis_tvalid;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata;
  logic         m_axis_tvalid;
  logic         m_axis_tready;
  logic [143:0] m_axis_tdata;
  logic         m_axis_tlast;
  logic [1:0]   m_axis_tuser;

  int fail_count;
  int pending_count;
  int words_checked;
  int frames_checked;
  int bytes_sent;
  int frames_sent;
  int cycle_count;
  bit idling_on;

  length_prefixed_frame_deframer i_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
  );

  length_prefixed_frame_deframer_checker i_checker (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .s_axis_tvalid    (s_axis_tvalid),
    .s_axis_tready    (s_axis_tready),
    .s_axis_tdata     (s_axis_tdata),
    .m_axis_tvalid    (m_axis_tvalid),
    .m_axis_tready    (m_axis_tready),
    .m_axis_tdata     (m_axis_tdata),
    .m_axis_tlast     (m_axis_tlast),
    .m_axis_tuser     (m_axis_tuser),
    .fail_count_o     (fail_count),
    .pending_count_o  (pending_count),
    .words_checked_o  (words_checked),
    .frames_checked_o (frames_checked)
  );

  // Clock
  initial clk_i = 1'b0;
  always #5 clk_i = ~clk_i;

  // Bound the run
  initial cycle_count = 0;
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d words outstanding",
               cycle_count, pending_count);
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Receiver: stall in random bursts while idling is on
  initial begin
    int stall_left;
    stall_left    = 0;
    m_axis_tready = 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (stall_left > 0) begin
        stall_left--;
        m_axis_tready = 1'b0;
      end else if (idling_on && $urandom_range(0, 4) == 0) begin
        stall_left    = $urandom_range(1, 11) - 1;
        m_axis_tready = 1'b0;
      end else begin
        m_axis_tready = 1'b1;
      end
    end
  end

  // Offer one byte, with an optional idle burst first; called at a falling edge
  task automatic send_byte(input logic [7:0] b);
    if (idling_on && $urandom_range(0, 4) == 0) begin
      s_axis_tvalid = 1'b0;
      repeat ($urandom_range(1, 11)) @(negedge clk_i);
    end
    s_axis_tvalid = 1'b1;
    s_axis_tdata  = b;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    @(negedge clk_i);
    bytes_sent++;
  endtask

  // Send a header then the body bytes up to the frame end; fill < 0 means random
  task automatic send_frame(input logic [63:0] nl, input logic [63:0] pl,
                            input int fill);
    logic [63:0] body;
    int          i;
    body = nl + pl;
    for (i = 0; i < 8; i++) send_byte(nl[63-8*i -: 8]);
    for (i = 0; i < 8; i++) send_byte(pl[63-8*i -: 8]);
    for (i = 0; i < int'(body); i++) begin
      send_byte((fill < 0) ? 8'($urandom_range(0, 255)) : 8'(fill));
    end
    frames_sent++;
  endtask

  initial begin
    logic [63:0] nl;
    logic [63:0] body;
    int          start_count;
    bit          held_off;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    bytes_sent    = 0;
    frames_sent   = 0;
    idling_on     = 1'b1;
    held_off      = 1'b0;
    repeat (7) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed frames: empty frame, empty name, empty payload, plain frame
    send_frame(64'd0, 64'd0, 0);
    send_frame(64'd0, 64'd3, 8'hff);
    send_frame(64'd3, 64'd0, 0);
    send_frame(64'd2, 64'd4, -1);
    // Frame end on the header byte while the name end lies past it
    send_frame(64'd1, '1, -1);
    // Name end wrapped below the position: body bytes are payload
    send_frame(64'hffff_ffff_ffff_fff1, 64'd20, -1);
    // Name end at the top of the range: body bytes are all name
    send_frame(64'hffff_ffff_ffff_fff0, 64'd21, -1);
    // Name end wrapped just below the header end
    send_frame('1, 64'd4, -1);

    // Random frames: mostly short, some with wrapped lengths
    start_count = bytes_sent;
    while (bytes_sent - start_count < RandomBytes) begin
      if (bytes_sent - start_count > RandomBytes - QuietTail) idling_on = 1'b0;
      // Hold off once until the block has drained
      if (bytes_sent - start_count > RandomBytes / 2 && idling_on && !held_off) begin
        held_off      = 1'b1;
        s_axis_tvalid = 1'b0;
        wait (pending_count == 0);
        @(negedge clk_i);
      end
      case ($urandom_range(0, 9))
        0, 1, 2, 3, 4, 5: begin
          if ($urandom_range(0, 9) == 0) begin
            send_frame(64'd0, 64'd0, -1);
          end else begin
            send_frame(64'($urandom_range(0, 6)), 64'($urandom_range(0, 24)), -1);
          end
        end
        6, 7: begin
          nl   = {$urandom, $urandom};
          body = 64'($urandom_range(0, 24));
          send_frame(nl, body - nl, -1);
        end
        default: begin
          nl   = 64'($urandom_range(0, 30));
          body = 64'($urandom_range(0, 24));
          send_frame(nl, body - nl, -1);
        end
      endcase
    end
    s_axis_tvalid = 1'b0;

    // Drain, then leave time for stray words before the verdict
    wait (pending_count == 0);
    repeat (10) @(posedge clk_i);

    $display("sent %0d bytes in %0d frames; checked %0d words, %0d frame ends",
             bytes_sent, frames_sent, words_checked, frames_checked);
    $display("covered empty frames and names, wrapped end offsets, idle bursts");
    if (fail_count == 0) begin
      $display("CHECK OK");
    end else begin
      $display("%0d mismatches", fail_count);
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
